// ===== rtl/core/connection_sequence_table_defines.svh =====
// ---------------------------------------------------------------------------
// connection_sequence_table_defines
// assertion macros used by the connection table back end (cst_back)
// ---------------------------------------------------------------------------
`ifndef CONNECTION_SEQUENCE_TABLE_DEFINES_SVH
`define CONNECTION_SEQUENCE_TABLE_DEFINES_SVH

`ifndef SYNTH
// checked outside reset
`define CST_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("connection table assertion failed");
// checked on every edge, reset included
`define CST_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("connection table reset assertion failed");
`else
`define CST_ASSERT(lbl, prop)
`define CST_ASSERT_RST(lbl, prop)
`endif

`endif

// ===== rtl/core/cst_pkg.sv =====
// ---------------------------------------------------------------------------
// cst_pkg
// types and codes of the connection sequence table
// ---------------------------------------------------------------------------
package cst_pkg;

   localparam int CNT_W = 7;   // holds an entry count up to the largest depth

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_OPEN   = 2'd1;
   localparam logic [1:0] CMD_DATA   = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
   localparam logic [2:0] KIND_DISCARDED = 3'd1;
   localparam logic [2:0] KIND_UNKNOWN   = 3'd2;
   localparam logic [2:0] KIND_OPENED    = 3'd3;
   localparam logic [2:0] KIND_REPLIED   = 3'd4;
   localparam logic [2:0] KIND_REFUSED   = 3'd5;
   localparam logic [2:0] KIND_EVICTED   = 3'd6;
   localparam logic [2:0] KIND_TICK_IDLE = 3'd7;

   localparam logic [1:0] CSR_WRAP_MARGIN   = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT_MS    = 2'd1;
   localparam logic [1:0] CSR_ADDRESS_LIMIT = 2'd2;
   localparam logic [1:0] CSR_TABLE_LIMIT   = 2'd3;

   localparam logic [15:0] SEQ_TOP = 16'hFFFF;

   typedef enum logic [1:0] {
      OP_TICK,
      OP_OPEN,
      OP_DATA,
      OP_NONE
   } op_type;

   typedef enum logic {
      ST_LOOK,
      ST_APPLY
   } state_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] peer_address;
      logic [15:0] peer_port;
      logic [15:0] sequence_req;
      logic [31:0] now_ms;
      logic [15:0] assigned_port;
      logic [31:0] session_key;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic        last_of_run;
      logic [3:0]  slot;
      logic [15:0] current_sequence;
      logic [31:0] lost_count;
      logic [31:0] reply_key;
      logic [15:0] reply_port;
      logic [31:0] entry_address;
      logic [15:0] entry_port;
   } rsp_type;

   // classified request as queued between front and back
   typedef struct packed {
      op_type      op;
      logic [31:0] address;
      logic [15:0] key_port;
      logic [15:0] sequence_req;
      logic [31:0] now_ms;
      logic [31:0] session_key;
   } item_type;

   typedef struct packed {
      logic [15:0] wrap_margin;
      logic [30:0] timeout_ms;
      logic [4:0]  per_address_limit;
      logic [4:0]  table_limit;
   } cfg_type;

endpackage

// ===== rtl/core/cst_front.sv =====
// ---------------------------------------------------------------------------
// cst_front
// classifies each request and holds it in a two-entry queue for the back end
// ---------------------------------------------------------------------------
module cst_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cst_pkg::req_type  req_data,
   output logic              item_valid,
   input  logic              item_pop,
   output cst_pkg::item_type item
);

   cst_pkg::item_type q_ff [2];
   logic              wr_ff, wr_in;
   logic              rd_ff, rd_in;
   logic [1:0]        cnt_ff, cnt_in;
   cst_pkg::item_type cls;
   logic              push;

   always_comb begin
      cls.address      = req_data.peer_address;
      cls.sequence_req = req_data.sequence_req;
      cls.now_ms       = req_data.now_ms;
      cls.session_key  = req_data.session_key;
      // an open is keyed by the port it hands out
      cls.key_port     = req_data.peer_port;
      unique case (req_data.cmd)
         cst_pkg::CMD_TICK: begin
            cls.op = cst_pkg::OP_TICK;
         end
         cst_pkg::CMD_OPEN: begin
            cls.op       = cst_pkg::OP_OPEN;
            cls.key_port = req_data.assigned_port;
         end
         cst_pkg::CMD_DATA: begin
            cls.op = cst_pkg::OP_DATA;
         end
         cst_pkg::CMD_UNUSED: begin
            cls.op = cst_pkg::OP_NONE;
         end
      endcase
   end

   assign req_stall  = (cnt_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (cnt_ff != 2'd0);
   assign item       = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = item_pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end

endmodule

// ===== rtl/core/cst_back.sv =====
// ---------------------------------------------------------------------------
// cst_back
// connection table: parallel lookup, entry update and timeout eviction
// ---------------------------------------------------------------------------
`include "connection_sequence_table_defines.svh"

module cst_back #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  cst_pkg::cfg_type  cfg,
   input  logic              item_valid,
   output logic              item_pop,
   input  cst_pkg::item_type item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cst_pkg::rsp_type  rsp_data
);

   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW     = cst_pkg::CNT_W;

   cst_pkg::state_type      state_ff, state_in;
   logic [TABLE_DEPTH-1:0]  valid_ff, valid_in;
   logic [31:0]             addr_ff [TABLE_DEPTH];
   logic [15:0]             port_ff [TABLE_DEPTH];
   logic [15:0]             seq_ff [TABLE_DEPTH];
   logic                    armed_ff [TABLE_DEPTH];
   logic [31:0]             lost_ff [TABLE_DEPTH];
   logic [31:0]             time_ff [TABLE_DEPTH];

   cst_pkg::item_type       cur_ff;
   logic [TABLE_DEPTH-1:0]  addr_hit_ff, key_hit_ff, evict_ff;
   logic [TABLE_DEPTH-1:0]  addr_hit, key_hit, evict;
   logic                    rsp_valid_ff;
   cst_pkg::rsp_type        rsp_ff, rsp_in;

   logic                    out_free, fire, more;
   logic [CW-1:0]           same_cnt, used_cnt, lim;
   logic [SLOT_W-1:0]       hit_idx, free_idx, ev_idx;
   logic                    hit, insert;
   logic [TABLE_DEPTH-1:0]  ev_rest;
   logic [15:0]             e_seq, seq_new;
   logic [31:0]             e_lost, lost_new;
   logic                    armed0, armed_new, ok;

   function automatic logic [SLOT_W-1:0] lowest(input logic [TABLE_DEPTH-1:0] v);
      logic [SLOT_W-1:0] r;
      r = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (v[i]) r = SLOT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [CW-1:0] count(input logic [TABLE_DEPTH-1:0] v);
      logic [CW-1:0] c;
      c = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         c = c + {{(CW-1){1'b0}}, v[i]};
      end
      return c;
   endfunction

   // lookup stage: compare every entry against the queue head
   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         logic [31:0] d, age;
         d           = item.now_ms - time_ff[i];
         age         = d[31] ? (32'd0 - d) : d;
         addr_hit[i] = valid_ff[i] && (addr_ff[i] == item.address);
         key_hit[i]  = addr_hit[i] && (port_ff[i] == item.key_port);
         evict[i]    = valid_ff[i] && (age > {1'b0, cfg.timeout_ms});
      end
   end

   // apply stage
   always_comb begin
      same_cnt = count(addr_hit_ff);
      used_cnt = count(valid_ff);
      lim      = ({2'b0, cfg.table_limit} > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                              : {2'b0, cfg.table_limit};
      hit      = |key_hit_ff;
      hit_idx  = lowest(key_hit_ff);
      free_idx = lowest(~valid_ff);
      ev_idx   = lowest(evict_ff);
      ev_rest  = evict_ff & ~(TABLE_DEPTH'(1) << ev_idx);
      insert   = (used_cnt < lim) && !(&valid_ff) && !hit;

      e_seq  = seq_ff[hit_idx];
      e_lost = lost_ff[hit_idx];
      armed0 = armed_ff[hit_idx] || (e_seq > (cst_pkg::SEQ_TOP - cfg.wrap_margin));
      if (e_seq > cur_ff.sequence_req) begin
         if (armed0 && (cur_ff.sequence_req < cfg.wrap_margin)) begin
            ok        = 1'b1;
            armed_new = 1'b0;
            lost_new  = e_lost;
         end else begin
            ok        = 1'b0;
            armed_new = armed0;
            lost_new  = e_lost + 32'd1;
         end
      end else begin
         ok        = 1'b1;
         armed_new = armed0;
         if ((cur_ff.sequence_req != 16'd0) && (e_seq != 16'd0)) begin
            lost_new = e_lost + {16'd0, cur_ff.sequence_req} - {16'd0, e_seq} - 32'd1;
         end else begin
            lost_new = e_lost;
         end
      end
      seq_new = ok ? cur_ff.sequence_req : e_seq;
   end

   always_comb begin
      rsp_in             = '0;
      rsp_in.last_of_run = 1'b1;
      more               = 1'b0;
      unique case (cur_ff.op)
         cst_pkg::OP_TICK: begin
            if (evict_ff == '0) begin
               rsp_in.kind = cst_pkg::KIND_TICK_IDLE;
            end else begin
               more                    = (ev_rest != '0);
               rsp_in.kind             = cst_pkg::KIND_EVICTED;
               rsp_in.last_of_run      = !more;
               rsp_in.slot             = 4'(ev_idx);
               rsp_in.current_sequence = seq_ff[ev_idx];
               rsp_in.lost_count       = lost_ff[ev_idx];
               rsp_in.entry_address    = addr_ff[ev_idx];
               rsp_in.entry_port       = port_ff[ev_idx];
            end
         end
         cst_pkg::OP_OPEN: begin
            if (same_cnt > {2'b0, cfg.per_address_limit}) begin
               rsp_in.kind = cst_pkg::KIND_REFUSED;
            end else if (insert) begin
               rsp_in.kind          = cst_pkg::KIND_OPENED;
               rsp_in.slot          = 4'(free_idx);
               rsp_in.reply_key     = cur_ff.session_key;
               rsp_in.reply_port    = cur_ff.key_port;
               rsp_in.entry_address = cur_ff.address;
               rsp_in.entry_port    = cur_ff.key_port;
            end else begin
               rsp_in.kind       = cst_pkg::KIND_REPLIED;
               rsp_in.reply_key  = cur_ff.session_key;
               rsp_in.reply_port = cur_ff.key_port;
            end
         end
         cst_pkg::OP_DATA: begin
            if (!hit) begin
               rsp_in.kind = cst_pkg::KIND_UNKNOWN;
            end else begin
               rsp_in.kind             = ok ? cst_pkg::KIND_ACCEPTED
                                            : cst_pkg::KIND_DISCARDED;
               rsp_in.slot             = 4'(hit_idx);
               rsp_in.current_sequence = seq_new;
               rsp_in.lost_count       = lost_new;
               rsp_in.entry_address    = addr_ff[hit_idx];
               rsp_in.entry_port       = port_ff[hit_idx];
            end
         end
         cst_pkg::OP_NONE: begin
            rsp_in.kind = cst_pkg::KIND_TICK_IDLE;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cst_pkg::ST_LOOK: begin
            if (item_valid) state_in = cst_pkg::ST_APPLY;
         end
         cst_pkg::ST_APPLY: begin
            if (out_free && !more) state_in = cst_pkg::ST_LOOK;
         end
      endcase
   end

   // state outputs
   always_comb begin
      item_pop = 1'b0;
      fire     = 1'b0;
      unique case (state_ff)
         cst_pkg::ST_LOOK: begin
            item_pop = item_valid;
         end
         cst_pkg::ST_APPLY: begin
            fire = out_free;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         if ((cur_ff.op == cst_pkg::OP_TICK) && (evict_ff != '0)) begin
            valid_in[ev_idx] = 1'b0;
         end else if ((cur_ff.op == cst_pkg::OP_OPEN) &&
                      (rsp_in.kind == cst_pkg::KIND_OPENED)) begin
            valid_in[free_idx] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cst_pkg::ST_LOOK;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         cur_ff      <= item;
         addr_hit_ff <= addr_hit;
         key_hit_ff  <= key_hit;
         evict_ff    <= evict;
      end else if (fire && (cur_ff.op == cst_pkg::OP_TICK)) begin
         evict_ff <= ev_rest;
      end
      if (fire) begin
         rsp_ff <= rsp_in;
         if ((cur_ff.op == cst_pkg::OP_DATA) && hit) begin
            seq_ff[hit_idx]   <= seq_new;
            armed_ff[hit_idx] <= armed_new;
            lost_ff[hit_idx]  <= lost_new;
            if (ok) time_ff[hit_idx] <= cur_ff.now_ms;
         end
         if ((cur_ff.op == cst_pkg::OP_OPEN) && (rsp_in.kind == cst_pkg::KIND_OPENED)) begin
            addr_ff[free_idx]  <= cur_ff.address;
            port_ff[free_idx]  <= cur_ff.key_port;
            seq_ff[free_idx]   <= 16'd0;
            armed_ff[free_idx] <= 1'b0;
            lost_ff[free_idx]  <= 32'd0;
            time_ff[free_idx]  <= cur_ff.now_ms;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `CST_ASSERT(a_evict_only_valid, (state_ff == cst_pkg::ST_APPLY) |-> ((evict_ff & ~valid_ff) == '0))
   `CST_ASSERT(a_rsp_from_apply, $rose(rsp_valid_ff) |-> $past(state_ff == cst_pkg::ST_APPLY))
   `CST_ASSERT_RST(a_reset_clears, $past(reset) |-> ((valid_ff == '0) && !rsp_valid_ff))

endmodule

// ===== rtl/core/connection_sequence_table.sv =====
// ---------------------------------------------------------------------------
// connection_sequence_table
// connection table keyed by address and port with sequence tracking,
// open admission and timeout eviction
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// req_      in         valid / stall      cst_pkg::req_type
// rsp_      out        valid / stall      cst_pkg::rsp_type
// csr_      in         valid / ready      index (2) + wdata (31)
//
// an item passes the back end in the lookup state, a parallel compare of
// all entries, then the apply state, the entry update and the result register
// a tick stays in the apply state until each evicted entry has its response
// a two-entry queue takes requests while the back end works or rsp_ stalls
// reset clears the valid bits and all control state at the clock edge of a reset cycle
// ---------------------------------------------------------------------------
module connection_sequence_table #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cst_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cst_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [1:0]       csr_index,
   input  logic [30:0]      csr_wdata
);

   cst_pkg::cfg_type  cfg_ff;
   cst_pkg::item_type item;
   logic              item_valid, item_pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wrap_margin       <= 16'd13107;
         cfg_ff.timeout_ms        <= 31'd5000;
         cfg_ff.per_address_limit <= 5'd4;
         cfg_ff.table_limit       <= 5'd16;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cst_pkg::CSR_WRAP_MARGIN:   cfg_ff.wrap_margin       <= csr_wdata[15:0];
            cst_pkg::CSR_TIMEOUT_MS:    cfg_ff.timeout_ms        <= csr_wdata;
            cst_pkg::CSR_ADDRESS_LIMIT: cfg_ff.per_address_limit <= csr_wdata[4:0];
            cst_pkg::CSR_TABLE_LIMIT:   cfg_ff.table_limit       <= csr_wdata[4:0];
         endcase
      end
   end

   cst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   cst_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
